### sv/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [7:0] LowAChar  = 8'h61;
  localparam logic [7:0] LowFChar  = 8'h66;
  localparam logic [7:0] UpAChar   = 8'h41;
  localparam logic [7:0] DigitTen  = 8'd10;

  // results one input word can cause
  localparam int unsigned MaxPush  = 2;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // results handed from the decoder to the output queue
  typedef struct packed {
    logic [1:0] num;
    out_word_t  first;
    out_word_t  second;
  } push_t;

  // hex digit value, garbage but deterministic for non-hex bytes
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= ZeroChar && c <= NineChar) begin
      v = c - ZeroChar;
    end else if (c >= LowAChar && c <= LowFChar) begin
      v = c - LowAChar + DigitTen;
    end else begin
      v = c - UpAChar + DigitTen;
    end
    return v;
  endfunction

endpackage

### sv/url_percent_decoder.sv
// streaming percent-escape decoder
// input channel: in_valid_i / in_ready_o carry one raw byte word with a
// last flag; output channel: out_valid_o / out_ready_i carry decoded words
// a '%' followed by two more bytes of the same string becomes one byte
// built from the two hex digits; other bytes pass through unchanged
// if a string ends right after '%' or after '%' and one byte, the held
// bytes come out literally, the final one flagged last
// an accepted word pushes its result straight into the output queue;
// escape bytes push nothing until the low digit arrives
// throughput: one input word per cycle while the queue has room; the end
// flush of '%' and one byte puts two words into the output queue at once,
// and the output side drains them one word at a time
// the output queue holds four words and takes input while it has room
// for two, so a stalled receiver fills it and then in_ready_o drops
// reset clears the escape phase and empties the queue
module url_percent_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  upd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output upd_pkg::out_word_t out_word_o
);
  import upd_pkg::*;

  push_t push;
  logic  room;
  logic  accept;

  // accept whenever the queue can absorb the worst-case push
  assign in_ready_o = room;
  assign accept     = in_valid_i & room;

  // escape state machine, results go straight into the queue
  upd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .push_o   (push)
  );

  // output queue decouples the receiver stall from the input side
  upd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

### sv/upd_decode.sv
module upd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  upd_pkg::in_word_t word_i,
  output upd_pkg::push_t    push_o
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_HIGH
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [7:0] dec_byte;

  // only the low nibble of the high digit survives the modulo 256
  assign hi_val   = digit_value(held_q);
  assign lo_val   = digit_value(word_i.in_byte);
  assign dec_byte = {hi_val[3:0], 4'b0000} + lo_val;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    push_o  = '0;
    unique case (phase_q)
      PH_PCT: begin
        if (word_i.in_last) begin
          // string ended one byte after the percent: flush both literally
          push_o.num    = 2'd2;
          push_o.first  = '{out_byte: PctChar, out_last: 1'b0};
          push_o.second = '{out_byte: word_i.in_byte, out_last: 1'b1};
          phase_d       = PH_IDLE;
        end else begin
          held_d  = word_i.in_byte;
          phase_d = PH_HIGH;
        end
      end
      PH_HIGH: begin
        push_o.num   = 2'd1;
        push_o.first = '{out_byte: dec_byte, out_last: word_i.in_last};
        phase_d      = PH_IDLE;
      end
      default: begin
        if (word_i.in_byte == PctChar && !word_i.in_last) begin
          phase_d = PH_PCT;
        end else begin
          push_o.num   = 2'd1;
          push_o.first = '{out_byte: word_i.in_byte, out_last: word_i.in_last};
          phase_d      = PH_IDLE;
        end
      end
    endcase
    if (!accept_i) begin
      push_o.num = 2'd0;
      phase_d    = phase_q;
      held_d     = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

### sv/upd_out_queue.sv
module upd_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upd_pkg::push_t     push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output upd_pkg::out_word_t out_word_o
);
  import upd_pkg::*;

  out_word_t          mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               pop;

  // room for a full two-word push
  assign room_o      = cnt_q <= QCntW'(QDepth - MaxPush);
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign cnt_d       = cnt_q + QCntW'(push_i.num) - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_i.num);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

endmodule

### sv/upd_checker.sv
module upd_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input upd_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input upd_pkg::out_word_t out_word_o
);
  import upd_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // backpressure only while results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a last word always yields at least one result
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.in_last |=> out_valid_o)
    else $error("last word produced no result");

  // after a two-word flush pops its first word, the final word is still waiting
  a_flush_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.in_last && !out_valid_o
    ##1 out_valid_o && out_ready_i && !out_word_o.out_last |=> out_valid_o)
    else $error("flush lost its final word");

endmodule

bind url_percent_decoder upd_props u_upd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
